// File: src/bcec_pkg.sv
`timescale 1ns / 1ps

package bcec_pkg;

    // Key codes on the result channel
    localparam logic [2:0] KC_NONE  = 3'd0;
    localparam logic [2:0] KC_ENTER = 3'd1;
    localparam logic [2:0] KC_EXIT  = 3'd2;
    localparam logic [2:0] KC_UP    = 3'd3;
    localparam logic [2:0] KC_DOWN  = 3'd4;
    localparam logic [2:0] KC_RESET = 3'd5;

    // Press phase codes
    localparam logic [1:0] PHASE_IDLE     = 2'd0;
    localparam logic [1:0] PHASE_PRESSED  = 2'd1;
    localparam logic [1:0] PHASE_RELEASED = 2'd2;
    localparam logic [1:0] PHASE_DONE     = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_CLICK_WINDOW = 2'd0;
    localparam logic [1:0] REG_RESET_HOLD   = 2'd1;
    localparam logic [1:0] REG_REPEAT_DELAY = 2'd2;
    localparam logic [1:0] REG_REPEAT_STEP  = 2'd3;

    // Register reset values
    localparam logic [7:0]  CLICK_WINDOW_RST = 8'd15;
    localparam logic [7:0]  RESET_HOLD_RST   = 8'd200;
    localparam logic [15:0] REPEAT_DELAY_RST = 16'd50;
    localparam logic [15:0] REPEAT_STEP_RST  = 16'd10;

endpackage

// File: src/button_click_event_classifier.sv
`timescale 1ns / 1ps

// Button click classifier: one item is one scan tick carrying the raw
// active-low button level and the two encoder-turn pulses; each item yields
// exactly one result item with a key code (none, enter, exit, up, down,
// reset). Double click (exit) is told apart from single click and long
// press (both enter) by click_window, a continuous hold beyond reset_hold
// gives reset, and an unchanged nonzero code is re-emitted repeat_delay + 1
// ticks after it first appeared and then every repeat_step + 1 ticks (every
// repeat_delay + 1 ticks when repeat_step is not below repeat_delay). The
// block takes one item per clock while its result is drained: all state is
// updated in the cycle an item is accepted and the key code lands in an
// output register, which may be drained in the same cycle a new item is
// taken. The result is valid in the cycle after acceptance.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_data
// and should only be changed while no item is in flight.
module button_click_event_classifier (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_button_level,
    input  logic        s_left_turn,
    input  logic        s_right_turn,
    // result items
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_key_code
);

    // configuration
    logic [7:0]  click_window_reg;
    logic [7:0]  reset_hold_reg;
    logic [15:0] repeat_delay_reg;
    logic [15:0] repeat_step_reg;

    // classifier state
    logic [1:0]  phase_reg,        phase_next;
    logic [7:0]  press_ticks_reg,  press_ticks_next;
    logic [7:0]  hold_ticks_reg,   hold_ticks_next;
    logic        left_pend_reg,    left_pend_next;
    logic        right_pend_reg,   right_pend_next;
    logic [2:0]  last_code_reg,    last_code_next;
    logic [15:0] repeat_ticks_reg, repeat_ticks_next;

    // output register
    logic        out_valid_reg;
    logic [2:0]  out_code_reg;
    logic [2:0]  result_next;

    logic        accept;
    logic        pressed;
    logic [7:0]  hold_inc;
    logic [7:0]  press_bump;
    logic [15:0] repeat_inc;
    logic [15:0] repeat_reload;
    logic [2:0]  code;
    logic        done;

    assign s_ready    = !out_valid_reg || m_ready;
    assign accept     = s_valid && s_ready;
    assign m_valid    = out_valid_reg;
    assign m_key_code = out_code_reg;

    assign pressed       = !s_button_level;
    assign hold_inc      = hold_ticks_reg + 8'd1;
    assign press_bump    = (press_ticks_reg == 8'hFF) ? 8'hFF : press_ticks_reg + 8'd1;
    assign repeat_inc    = (repeat_ticks_reg == 16'hFFFF) ? 16'hFFFF
                                                          : repeat_ticks_reg + 16'd1;
    assign repeat_reload = (repeat_delay_reg > repeat_step_reg)
                         ? repeat_delay_reg - repeat_step_reg : 16'd0;

    // Classification of one tick: hold check, press phase, then turns
    always_comb begin
        phase_next       = phase_reg;
        press_ticks_next = press_ticks_reg;
        hold_ticks_next  = hold_ticks_reg;
        left_pend_next   = left_pend_reg  || s_left_turn;
        right_pend_next  = right_pend_reg || s_right_turn;
        code             = bcec_pkg::KC_NONE;
        done             = 1'b0;

        // continuous hold
        if (pressed) begin
            if (hold_inc > reset_hold_reg) begin
                hold_ticks_next = 8'd0;
                code            = bcec_pkg::KC_RESET;
                done            = 1'b1;
            end else begin
                hold_ticks_next = hold_inc;
            end
        end else begin
            hold_ticks_next = 8'd0;
        end

        // press phase machine
        if (!done) begin
            unique case (phase_reg)
                bcec_pkg::PHASE_IDLE: begin
                    if (pressed) begin
                        phase_next = bcec_pkg::PHASE_PRESSED;
                    end
                end
                bcec_pkg::PHASE_PRESSED: begin
                    press_ticks_next = press_bump;
                    if (press_bump > click_window_reg) begin
                        // timeout wins over a release on the same tick
                        phase_next = bcec_pkg::PHASE_DONE;
                        code       = bcec_pkg::KC_ENTER;
                        done       = 1'b1;
                    end else if (!pressed) begin
                        phase_next = bcec_pkg::PHASE_RELEASED;
                    end
                end
                bcec_pkg::PHASE_RELEASED: begin
                    press_ticks_next = press_bump;
                    if (press_bump < click_window_reg) begin
                        if (pressed) begin
                            phase_next = bcec_pkg::PHASE_DONE;
                            code       = bcec_pkg::KC_EXIT;
                            done       = 1'b1;
                        end
                    end else begin
                        phase_next = bcec_pkg::PHASE_DONE;
                        code       = bcec_pkg::KC_ENTER;
                        done       = 1'b1;
                    end
                end
                default: begin
                    if (!pressed) begin
                        phase_next       = bcec_pkg::PHASE_IDLE;
                        press_ticks_next = 8'd0;
                    end
                end
            endcase
        end

        // encoder turns, left first
        if (!done) begin
            if (left_pend_next) begin
                left_pend_next = 1'b0;
                code           = bcec_pkg::KC_UP;
            end else if (right_pend_next) begin
                right_pend_next = 1'b0;
                code            = bcec_pkg::KC_DOWN;
            end
        end
    end

    // Auto-repeat stage
    always_comb begin
        last_code_next    = last_code_reg;
        repeat_ticks_next = repeat_ticks_reg;
        result_next       = bcec_pkg::KC_NONE;
        if (code != last_code_reg) begin
            last_code_next    = code;
            repeat_ticks_next = 16'd0;
            result_next       = code;
        end else if (code != bcec_pkg::KC_NONE) begin
            if (repeat_inc > repeat_delay_reg) begin
                repeat_ticks_next = repeat_reload;
                result_next       = code;
            end else begin
                repeat_ticks_next = repeat_inc;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            click_window_reg <= bcec_pkg::CLICK_WINDOW_RST;
            reset_hold_reg   <= bcec_pkg::RESET_HOLD_RST;
            repeat_delay_reg <= bcec_pkg::REPEAT_DELAY_RST;
            repeat_step_reg  <= bcec_pkg::REPEAT_STEP_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bcec_pkg::REG_CLICK_WINDOW: click_window_reg <= cfg_data[7:0];
                bcec_pkg::REG_RESET_HOLD:   reset_hold_reg   <= cfg_data[7:0];
                bcec_pkg::REG_REPEAT_DELAY: repeat_delay_reg <= cfg_data;
                bcec_pkg::REG_REPEAT_STEP:  repeat_step_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // State update on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= bcec_pkg::PHASE_IDLE;
            press_ticks_reg  <= 8'd0;
            hold_ticks_reg   <= 8'd0;
            left_pend_reg    <= 1'b0;
            right_pend_reg   <= 1'b0;
            last_code_reg    <= bcec_pkg::KC_NONE;
            repeat_ticks_reg <= 16'd0;
        end else if (accept) begin
            phase_reg        <= phase_next;
            press_ticks_reg  <= press_ticks_next;
            hold_ticks_reg   <= hold_ticks_next;
            left_pend_reg    <= left_pend_next;
            right_pend_reg   <= right_pend_next;
            last_code_reg    <= last_code_next;
            repeat_ticks_reg <= repeat_ticks_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_code_reg <= result_next;
        end
    end

    // Checks
    a_result_follows_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("no result after an accepted item");

    a_code_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_key_code <= bcec_pkg::KC_RESET))
        else $error("key code out of range");

    a_idle_no_ticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == bcec_pkg::PHASE_IDLE) |-> (press_ticks_reg == 8'd0))
        else $error("press ticks left over in idle phase");

    a_idle_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(phase_reg) == bcec_pkg::PHASE_IDLE) |->
            (phase_reg == bcec_pkg::PHASE_IDLE || phase_reg == bcec_pkg::PHASE_PRESSED))
        else $error("illegal phase step out of idle");

    a_repeat_changes_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && code != last_code_reg) |=> (repeat_ticks_reg == 16'd0))
        else $error("repeat counter not cleared on a new code");

endmodule

// File: tb/button_click_event_classifier_tb.sv
`timescale 1ns / 1ps

module button_click_event_classifier_tb;

    localparam int CLK_PERIOD = 8;
    localparam int RUN_LIMIT  = 4_000_000;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        cfg_wr_en      = 1'b0;
    logic [1:0]  cfg_index      = bcec_pkg::REG_CLICK_WINDOW;
    logic [15:0] cfg_data       = '0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic        s_button_level = 1'b1;
    logic        s_left_turn    = 1'b0;
    logic        s_right_turn   = 1'b0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [2:0]  m_key_code;

    // shared control of the stimulus and the receiver
    bit          idle_en     = 1'b0;
    int          hold_cycles = 0;
    int          ticks_sent  = 0;
    int          err_cnt     = 0;

    // key codes still to come out, oldest first
    logic [2:0]  key_q[$];
    logic [2:0]  want_key;

    // predictor copy of the registers
    logic [7:0]  cw_reg = bcec_pkg::CLICK_WINDOW_RST;
    logic [7:0]  rh_reg = bcec_pkg::RESET_HOLD_RST;
    logic [15:0] rd_reg = bcec_pkg::REPEAT_DELAY_RST;
    logic [15:0] rs_reg = bcec_pkg::REPEAT_STEP_RST;

    // predictor copy of the state
    logic [1:0]  btn_phase     = bcec_pkg::PHASE_IDLE;
    logic [7:0]  btn_ticks     = '0;
    logic [7:0]  hold_cnt      = '0;
    logic        left_latched  = 1'b0;
    logic        right_latched = 1'b0;
    logic [2:0]  prev_key      = bcec_pkg::KC_NONE;
    logic [15:0] rpt_cnt       = '0;

    button_click_event_classifier i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_button_level (s_button_level),
        .s_left_turn    (s_left_turn),
        .s_right_turn   (s_right_turn),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_key_code     (m_key_code)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Raw classification: hold check, then press phases, then turns
    function automatic logic [2:0] classify_press(input logic pressed);
        if (pressed) begin
            hold_cnt = hold_cnt + 8'd1;
            if (hold_cnt > rh_reg) begin
                hold_cnt = '0;
                return bcec_pkg::KC_RESET;
            end
        end else begin
            hold_cnt = '0;
        end

        case (btn_phase)
            bcec_pkg::PHASE_IDLE: begin
                if (pressed)
                    btn_phase = bcec_pkg::PHASE_PRESSED;
            end
            bcec_pkg::PHASE_PRESSED: begin
                if (btn_ticks != 8'hFF)
                    btn_ticks = btn_ticks + 8'd1;
                if (!pressed)
                    btn_phase = bcec_pkg::PHASE_RELEASED;
                // timeout beats a release on the same tick
                if (btn_ticks > cw_reg) begin
                    btn_phase = bcec_pkg::PHASE_DONE;
                    return bcec_pkg::KC_ENTER;
                end
            end
            bcec_pkg::PHASE_RELEASED: begin
                if (btn_ticks != 8'hFF)
                    btn_ticks = btn_ticks + 8'd1;
                if (btn_ticks < cw_reg) begin
                    if (pressed) begin
                        btn_phase = bcec_pkg::PHASE_DONE;
                        return bcec_pkg::KC_EXIT;
                    end
                end else begin
                    btn_phase = bcec_pkg::PHASE_DONE;
                    return bcec_pkg::KC_ENTER;
                end
            end
            default: begin
                if (!pressed) begin
                    btn_phase = bcec_pkg::PHASE_IDLE;
                    btn_ticks = '0;
                end
            end
        endcase

        // left wins over right
        if (left_latched) begin
            left_latched = 1'b0;
            return bcec_pkg::KC_UP;
        end
        if (right_latched) begin
            right_latched = 1'b0;
            return bcec_pkg::KC_DOWN;
        end
        return bcec_pkg::KC_NONE;
    endfunction

    // Key code for one tick, after the auto-repeat stage
    function automatic logic [2:0] predict_key(input logic level, input logic left,
                                               input logic right);
        logic [2:0] code;
        logic [2:0] key;
        key = bcec_pkg::KC_NONE;
        if (left)
            left_latched = 1'b1;
        if (right)
            right_latched = 1'b1;
        code = classify_press(!level);
        if (code != prev_key) begin
            prev_key = code;
            rpt_cnt  = '0;
            key      = code;
        end else if (code != bcec_pkg::KC_NONE) begin
            if (rpt_cnt != 16'hFFFF)
                rpt_cnt = rpt_cnt + 16'd1;
            if (rpt_cnt > rd_reg) begin
                rpt_cnt = (rd_reg > rs_reg) ? rd_reg - rs_reg : '0;
                key     = code;
            end
        end
        return key;
    endfunction

    // Send one tick; the key code is predicted when the item is taken
    task automatic send_tick(input logic level, input logic left, input logic right);
        int gap;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_button_level <= level;
        s_left_turn    <= left;
        s_right_turn   <= right;
        do @(posedge aclk); while (!s_ready);
        key_q.push_back(predict_key(level, left, right));
        ticks_sent++;
    endtask

    // Stop offering items and let every result come out
    task automatic settle_block();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (key_q.size() == 0);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            bcec_pkg::REG_CLICK_WINDOW: cw_reg = data[7:0];
            bcec_pkg::REG_RESET_HOLD:   rh_reg = data[7:0];
            bcec_pkg::REG_REPEAT_DELAY: rd_reg = data;
            default:                    rs_reg = data;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // junk and its inverse fill the unused upper byte of the 8-bit registers
    task automatic apply_settings(input logic [7:0] cw, input logic [7:0] rh,
                                  input logic [15:0] rd, input logic [15:0] rs,
                                  input logic [7:0] junk);
        settle_block();
        write_reg(bcec_pkg::REG_CLICK_WINDOW, {junk, cw});
        write_reg(bcec_pkg::REG_RESET_HOLD, {~junk, rh});
        write_reg(bcec_pkg::REG_REPEAT_DELAY, rd);
        write_reg(bcec_pkg::REG_REPEAT_STEP, rs);
    endtask

    function automatic logic turn_bit(input bit spin);
        return spin | ($urandom_range(0, 7) == 0);
    endfunction

    // Mostly press/release runs sized around the click window, some noise
    task automatic run_random(input int n_items);
        int  stop_at;
        int  cap;
        int  len;
        bit  spin_l;
        bit  spin_r;
        stop_at = ticks_sent + n_items;
        while (ticks_sent < stop_at) begin
            cap    = (cw_reg > 8'd20) ? 24 : int'(cw_reg) + 4;
            spin_l = ($urandom_range(0, 5) == 0);
            spin_r = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 4) == 0) begin
                len = $urandom_range(1, 6);
                repeat (len)
                    send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
            end else begin
                if ($urandom_range(0, 5) == 0)
                    len = $urandom_range(cap, cap + ((rh_reg < 8'd30) ? int'(rh_reg) + 2 : 8));
                else
                    len = $urandom_range(1, cap);
                repeat (len) send_tick(1'b0, turn_bit(spin_l), turn_bit(spin_r));
                len = $urandom_range(1, cap);
                repeat (len) send_tick(1'b1, turn_bit(spin_l), turn_bit(spin_r));
            end
        end
    endtask

    task automatic test_reset_values();
        idle_en = 1'b1;
        run_random(30);
    endtask

    // Every key code and the click corner cases with a tiny window
    task automatic test_click_cases();
        idle_en = 1'b0;
        apply_settings(8'd3, 8'd5, 16'd1, 16'd3, 8'h00);
        // single click: short press, window runs out after release
        send_tick(1'b0, 1'b0, 1'b0);
        repeat (3) send_tick(1'b1, 1'b0, 1'b0);
        // double click
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        // long press running on into a reset
        repeat (6) send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        // release on the very tick the window times out
        repeat (4) send_tick(1'b0, 1'b0, 1'b0);
        repeat (2) send_tick(1'b1, 1'b0, 1'b0);
        // both turns at once: up first, then down
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b1, 1'b0, 1'b0);
        // steady left turns: auto-repeat, reload saturating at zero
        repeat (4) send_tick(1'b1, 1'b1, 1'b0);
    endtask

    task automatic test_register_extremes();
        idle_en = 1'b1;
        apply_settings(8'd1, 8'd1, 16'd1, 16'd0, 8'h00);
        run_random(30);
        apply_settings(8'd254, 8'd254, 16'hFFFF, 16'hFFFF, 8'hFF);
        run_random(30);
        apply_settings(8'd0, 8'd0, 16'd0, 16'd0, 8'hA5);
        run_random(30);
        apply_settings(8'd255, 8'd255, 16'd1, 16'hFFFF, 8'h5A);
        run_random(30);
    endtask

    task automatic test_random_settings();
        repeat (3) begin
            idle_en = $urandom_range(0, 3) != 0;
            apply_settings(8'($urandom_range(1, 12)), 8'($urandom_range(1, 30)),
                           16'($urandom_range(1, 8)), 16'($urandom_range(0, 10)),
                           8'($urandom_range(0, 255)));
            run_random(40);
        end
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        idle_en     = 1'b0;
        hold_cycles = 60;
        run_random(40);
    endtask

    task automatic test_steady_stream();
        idle_en = 1'b0;
        apply_settings(8'd4, 8'd12, 16'd3, 16'd1, 8'h00);
        run_random(40);
    endtask

    // Receiver: long hold-off on request, else random stall bursts when idle_en is set
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                m_ready    <= 1'b0;
                stall_left = $urandom_range(1, 12) - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare each key code taken with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (key_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("%0t: key code %0d with none predicted", $realtime, m_key_code);
            end else begin
                want_key = key_q.pop_front();
                if (m_key_code !== want_key) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: key code expected %0d, got %0d",
                                 $realtime, want_key, m_key_code);
                end
            end
        end
    end

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        test_reset_values();
        test_click_cases();
        test_register_extremes();
        test_random_settings();
        test_backpressure();
        test_steady_stream();

        settle_block();
        if (err_cnt == 0 && key_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
